/* design/tvp_pkg.sv */
// Package for the triangle vertex projection block: widths, register codes, types and scale constants.
`default_nettype none
package tvp_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CW = 32;
	localparam int OW = 13;
	localparam int NV = 3;
	localparam int NQ = 14;
	localparam int NW = 80;
	localparam int DW = 49;
	localparam int QS = 2;
	localparam int NST = NQ / QS;
	localparam int LAT = NST + 3;

	typedef enum logic [2:0] {
		REG_X_SCALE = 3'd0,
		REG_X_DEPTH = 3'd1,
		REG_Y_SCALE = 3'd2,
		REG_Y_DEPTH = 3'd3,
		REG_D_SCALE = 3'd4,
		REG_D_OFFSET = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] x_scale;
		logic signed [CW-1:0] x_depth;
		logic signed [CW-1:0] y_scale;
		logic signed [CW-1:0] y_depth;
		logic signed [CW-1:0] d_scale;
		logic signed [CW-1:0] d_offset;
	} coef_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} vtx_t;

	typedef struct packed {
		logic signed [OW-1:0] x;
		logic signed [OW-1:0] y;
		logic signed [OW-1:0] d;
	} scr_t;

	localparam logic [NW-1:0] K_X = NW'(960);
	localparam logic [NW-1:0] K_Y = NW'(540);
	localparam logic [NW-1:0] K_D = NW'(255);
endpackage
`default_nettype wire

/* design/tvp_div.sv */
// Pipelined restoring divider: trunc(n/d) saturated to 13-bit signed.
`default_nettype none
module tvp_div
	import tvp_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic [NW-1:0] num,
	input wire logic [DW-1:0] den,
	input wire logic neg,
	output logic signed [OW-1:0] q
);
	logic [NW-1:0] rem_s [NST-1];
	logic [DW-1:0] den_s [NST-1];
	logic [NQ-1:0] q_s [NST];
	logic [NST-1:0] neg_s;
	logic [NW-1:0] rin [NST];
	logic [DW-1:0] din [NST];
	logic [NQ-1:0] qin [NST];
	logic [NW-1:0] rem_d [NST];
	logic [NQ-1:0] q_d [NST];

	always_comb begin
		rin[0] = num;
		din[0] = den;
		qin[0] = '0;
		for (int s = 1; s < NST; s++) begin
			rin[s] = rem_s[s-1];
			din[s] = den_s[s-1];
			qin[s] = q_s[s-1];
		end
		for (int s = 0; s < NST; s++) begin
			rem_d[s] = rin[s];
			q_d[s] = qin[s];
			for (int j = 0; j < QS; j++) begin
				if (rem_d[s] >= (NW'(din[s]) << (NQ - 1 - s * QS - j))) begin
					rem_d[s] = rem_d[s] - (NW'(din[s]) << (NQ - 1 - s * QS - j));
					q_d[s][NQ-1-s*QS-j] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s <= {neg_s[NST-2:0], neg};
			for (int s = 0; s < NST - 1; s++) begin
				rem_s[s] <= rem_d[s];
				den_s[s] <= din[s];
			end
			for (int s = 0; s < NST; s++) begin
				q_s[s] <= q_d[s];
			end
		end
	end

	// saturate: a negative quotient of at least 4096 gives -4096, a positive one of at least 4095 gives 4095
	always_comb begin
		if (neg_s[NST-1]) begin
			q = (q_s[NST-1] >= NQ'(4096)) ? OW'(13'h1000) : OW'(-$signed({1'b0, q_s[NST-1]}));
		end else begin
			q = (q_s[NST-1] >= NQ'(4095)) ? OW'(13'h0fff) : OW'(q_s[NST-1]);
		end
	end
endmodule
`default_nettype wire

/* design/tvp_lane.sv */
// One vertex lane: products, numerators, three dividers.
`default_nettype none
module tvp_lane
	import tvp_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire coef_t coef,
	input wire vtx_t vin,
	output scr_t sout,
	output logic zero
);
	logic signed [63:0] px_s1, pxz_s1, py_s1, pyz_s1, pdz_s1, pdo_s1;
	logic signed [CW+FRAC_BITS-1:0] den_s1, den_s2;
	logic signed [NW-1:0] nx_s2, ny_s2, nd_s2;
	logic [NW-1:0] ax_s3, ay_s3, ad_s3;
	logic [DW-1:0] dabs_s3;
	logic sx_s3, sy_s3, sd_s3;
	logic [LAT-1:0] zp_q;
	scr_t q;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= coef.x_scale * vin.x;
			pxz_s1 <= coef.x_depth * vin.z;
			py_s1 <= coef.y_scale * vin.y;
			pyz_s1 <= coef.y_depth * vin.z;
			pdz_s1 <= coef.d_scale * vin.z;
			pdo_s1 <= 64'(coef.d_offset) <<< FRAC_BITS;
			den_s1 <= (CW+FRAC_BITS)'(vin.z) <<< FRAC_BITS;
			nx_s2 <= NW'(px_s1) + NW'(pxz_s1) + NW'(den_s1);
			ny_s2 <= NW'(py_s1) + NW'(pyz_s1) + NW'(den_s1);
			nd_s2 <= NW'(pdz_s1) + NW'(pdo_s1);
			den_s2 <= den_s1;
			ax_s3 <= (nx_s2[NW-1] ? -nx_s2 : nx_s2) * K_X;
			ay_s3 <= (ny_s2[NW-1] ? -ny_s2 : ny_s2) * K_Y;
			ad_s3 <= (nd_s2[NW-1] ? -nd_s2 : nd_s2) * K_D;
			dabs_s3 <= den_s2[CW+FRAC_BITS-1] ? -DW'(den_s2) : DW'(den_s2);
			sx_s3 <= nx_s2[NW-1] ^ den_s2[CW+FRAC_BITS-1];
			sy_s3 <= ny_s2[NW-1] ^ den_s2[CW+FRAC_BITS-1];
			sd_s3 <= nd_s2[NW-1] ^ den_s2[CW+FRAC_BITS-1];
			zp_q <= {zp_q[LAT-2:0], vin.z == '0};
		end
	end

	tvp_div u_dx (.clk, .en, .num(ax_s3), .den(dabs_s3), .neg(sx_s3), .q(q.x));
	tvp_div u_dy (.clk, .en, .num(ay_s3), .den(dabs_s3), .neg(sy_s3), .q(q.y));
	tvp_div u_dd (.clk, .en, .num(ad_s3), .den(dabs_s3), .neg(sd_s3), .q(q.d));

	assign zero = zp_q[LAT-1];
	assign sout = zero ? '0 : q;
endmodule
`default_nettype wire

/* design/triangle_vertex_projection.sv */
// Top level: config registers, three vertex lanes, valid pipeline, output merge.
// Takes one triangle per cycle while the consumer is not stalling; the path from accept to
// the output register runs through three product/sum stages and a seven-stage divider (two
// quotient bits per stage) in each lane, then the output register. When the
// consumer stalls the whole pipeline holds; the output register keeps one finished word.
`default_nettype none
module triangle_vertex_projection
	import tvp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [287:0] s_tdata, // v0_x,v0_y,v0_z,v1_x,..,v2_z (32 each)
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [119:0] m_tdata, // s0_x,s0_y,s0_depth,..,s2_depth (13 each), mask(3)
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	coef_t coef_q;
	logic [LAT-1:0] vld_q;
	logic en;
	scr_t so [NV];
	logic [NV-1:0] zm;

	assign cfg_ready = 1'b1;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{x_scale: 32'sd65536, x_depth: '0, y_scale: 32'sd65536,
				y_depth: '0, d_scale: 32'sd65536, d_offset: '0};
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_X_SCALE: coef_q.x_scale <= cfg_data;
				REG_X_DEPTH: coef_q.x_depth <= cfg_data;
				REG_Y_SCALE: coef_q.y_scale <= cfg_data;
				REG_Y_DEPTH: coef_q.y_depth <= cfg_data;
				REG_D_SCALE: coef_q.d_scale <= cfg_data;
				REG_D_OFFSET: coef_q.d_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar v = 0; v < NV; v++) begin : g_lane
		tvp_lane u_lane (
			.clk, .en, .coef(coef_q),
			.vin(vtx_t'({s_tdata[96*v +: 32], s_tdata[96*v+32 +: 32], s_tdata[96*v+64 +: 32]})),
			.sout(so[v]), .zero(zm[v])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
			m_tvalid <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {zm, so[2].d, so[2].y, so[2].x, so[1].d, so[1].y, so[1].x,
				so[0].d, so[0].y, so[0].x};
		end
	end
endmodule
`default_nettype wire

/* design/tvp_checker.sv */
// Port-level checker for the projection block, bound to the top level.
`default_nettype none
module tvp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [119:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");
	a_zero2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[119] |-> m_tdata[116:78] == '0) else $error("zero vertex data");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[117] |-> m_tdata[38:0] == '0) else $error("zero vertex data");
endmodule

bind triangle_vertex_projection tvp_checker u_chk (.clk, .arst_n, .s_tready, .m_tvalid,
	.m_tready, .m_tdata);
`default_nettype wire
